// File: src/dsf_pkg.sv
// Package: shared constants and the force saturation function for the damped spring force block.
`default_nettype none
package dsf_pkg;
    localparam int FORCE_BITS = 27;
    localparam int GAIN_BITS  = 16;
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STIFFNESS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DAMPING   = 1'b1;

    // Clamp a wide signed value to the force range.
    function automatic logic signed [FORCE_BITS-1:0] sat_force(input logic signed [63:0] f);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (FORCE_BITS - 1)) - 64'sd1;
        lo = -(64'sd1 <<< (FORCE_BITS - 1));
        if (f > hi)
            sat_force = hi[FORCE_BITS-1:0];
        else if (f < lo)
            sat_force = lo[FORCE_BITS-1:0];
        else
            sat_force = f[FORCE_BITS-1:0];
    endfunction
endpackage
`default_nettype wire

// File: src/dsf_sqrt.sv
// Pipelined floor square root, one result bit per stage, with a side payload.
`default_nettype none
module dsf_sqrt #(
    parameter int IN_BITS  = 48,
    parameter int PAY_BITS = 8
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       en,
    input  wire                       in_valid,
    input  wire [IN_BITS-1:0]         radicand,
    input  wire [PAY_BITS-1:0]        pay_in,
    output logic                      out_valid,
    output logic [IN_BITS/2-1:0]      root,
    output logic [PAY_BITS-1:0]       pay_out
);
    localparam int RB = IN_BITS / 2;

    logic [RB:0]         vld_reg;
    logic [IN_BITS-1:0]  rem_reg  [RB+1];
    logic [RB-1:0]       r_reg    [RB+1];
    logic [IN_BITS-1:0]  src_reg  [RB+1];
    logic [PAY_BITS-1:0] pay_reg  [RB+1];

    always_comb
    begin
        rem_reg[0] = '0;
        r_reg[0]   = '0;
        src_reg[0] = radicand;
        pay_reg[0] = pay_in;
        vld_reg[0] = in_valid;
    end

    // Restoring digit recurrence: stage k brings in two radicand bits.
    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic [IN_BITS-1:0] rem_sh;
        logic [IN_BITS-1:0] trial;
        always_comb
        begin
            rem_sh = {rem_reg[k][IN_BITS-3:0], src_reg[k][IN_BITS-1 -: 2]};
            trial  = {{(IN_BITS-RB){1'b0}}, r_reg[k]} << 2 | {{(IN_BITS-1){1'b0}}, 1'b1};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                src_reg[k+1] <= src_reg[k] << 2;
                pay_reg[k+1] <= pay_reg[k];
                if (rem_sh >= trial)
                begin
                    rem_reg[k+1] <= rem_sh - trial;
                    r_reg[k+1]   <= {r_reg[k][RB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1] <= rem_sh;
                    r_reg[k+1]   <= {r_reg[k][RB-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[RB];
    assign root      = r_reg[RB];
    assign pay_out   = pay_reg[RB];
endmodule
`default_nettype wire

// File: src/dsf_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, with payload.
`default_nettype none
module dsf_div #(
    parameter int NB       = 24,
    parameter int PAY_BITS = 8
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 en,
    input  wire                 in_valid,
    input  wire [NB-1:0]        dividend,
    input  wire [NB-1:0]        divisor,
    input  wire [PAY_BITS-1:0]  pay_in,
    output logic                out_valid,
    output logic [NB-1:0]       quotient,
    output logic [PAY_BITS-1:0] pay_out
);
    logic [NB:0]         vld_reg;
    logic [NB-1:0]       rem_reg [NB+1];
    logic [NB-1:0]       q_reg   [NB+1];
    logic [NB-1:0]       dvs_reg [NB+1];
    logic [PAY_BITS-1:0] pay_reg [NB+1];

    always_comb
    begin
        vld_reg[0] = in_valid;
        rem_reg[0] = '0;
        q_reg[0]   = dividend;
        dvs_reg[0] = divisor;
        pay_reg[0] = pay_in;
    end

    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic [NB:0] sh;
        always_comb
            sh = {rem_reg[k], q_reg[k][NB-1]};
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dvs_reg[k+1] <= dvs_reg[k];
                pay_reg[k+1] <= pay_reg[k];
                if (sh >= {1'b0, dvs_reg[k]})
                begin
                    rem_reg[k+1] <= NB'(sh - {1'b0, dvs_reg[k]});
                    q_reg[k+1]   <= {q_reg[k][NB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1] <= sh[NB-1:0];
                    q_reg[k+1]   <= {q_reg[k][NB-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[NB];
    assign quotient  = q_reg[NB];
    assign pay_out   = pay_reg[NB];
endmodule
`default_nettype wire

// File: src/damped_spring_force_top.sv
// Top level: streaming damped spring force pipeline.
//
// One spring item enters per clock and one result item leaves per clock when
// the output side keeps tready high. The square root takes COORD_BITS+1
// stages, one result bit per stage. The three dividers (|d|*E/len) run in
// parallel and take 2*COORD_BITS+1 stages, one quotient bit per stage. Six
// more register stages add the rest. The whole pipeline advances together;
// s_axis_tready = m_axis_tready or output empty, so a stall freezes every
// stage and nothing is lost or repeated.
// s_axis_tdata, lowest bit first: pos_diff_x, pos_diff_y, pos_diff_z,
// vel_diff_x, vel_diff_y, vel_diff_z (COORD_BITS each), rest_length
// (COORD_BITS-1), zero pad to bytes. m_axis_tdata: force_x, force_y,
// force_z (27 each), stretched, zero pad to 88 bits.
// Config: cfg_index 0 = stiffness, 1 = velocity_damping; Q0.16 gains.
`default_nettype none
module damped_spring_force_top #(
    parameter int COORD_BITS = 24
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire [dsf_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire [dsf_pkg::GAIN_BITS-1:0]    cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // pos x,y,z, vel x,y,z, rest_length (low bit up), zero pad
    input  wire [((7*COORD_BITS-1)+7)/8*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // force_x, force_y, force_z, stretched (low bit up), zero pad
    output logic [87:0] m_axis_tdata
);
    localparam int CB  = COORD_BITS;
    localparam int FB  = dsf_pkg::FORCE_BITS;
    localparam int SB  = 2 * CB;          // squared-length width (even)
    localparam int LB  = CB;              // root MSB index (root is LB+1 bits)
    localparam int PAY = 3*CB + 3*CB + CB - 1 + 1;

    logic [dsf_pkg::GAIN_BITS-1:0] stiff_reg, damp_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_reg <= '0;
            damp_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dsf_pkg::REG_STIFFNESS: stiff_reg <= cfg_data;
                dsf_pkg::REG_DAMPING:   damp_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    assign en = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    // Stage 1: squares
    logic signed [CB-1:0] dx, dy, dz;
    logic [CB-2:0] rest_in;
    assign dx = s_axis_tdata[CB-1:0];
    assign dy = s_axis_tdata[2*CB-1:CB];
    assign dz = s_axis_tdata[3*CB-1:2*CB];
    assign rest_in = s_axis_tdata[7*CB-2:6*CB];

    logic [CB-1:0] mx, my, mz;
    assign mx = dx[CB-1] ? CB'(-dx) : CB'(dx);
    assign my = dy[CB-1] ? CB'(-dy) : CB'(dy);
    assign mz = dz[CB-1] ? CB'(-dz) : CB'(dz);

    logic v1_reg;
    logic [SB-1:0] sqx_reg, sqy_reg, sqz_reg, rr_reg;
    logic [7*CB-2:0] raw1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_axis_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg  <= {{CB{1'b0}}, mx} * {{CB{1'b0}}, mx};
            sqy_reg  <= {{CB{1'b0}}, my} * {{CB{1'b0}}, my};
            sqz_reg  <= {{CB{1'b0}}, mz} * {{CB{1'b0}}, mz};
            rr_reg   <= {{(CB+1){1'b0}}, rest_in} * {{(CB+1){1'b0}}, rest_in};
            raw1_reg <= s_axis_tdata[7*CB-2:0];
        end
    end

    // Stage 2: sum and stretch compare
    logic [SB+1:0] sum_next;
    assign sum_next = {2'b0, sqx_reg} + {2'b0, sqy_reg} + {2'b0, sqz_reg};
    logic v2_reg, str2_reg;
    logic [SB+1:0] sum2_reg;
    logic [7*CB-2:0] raw2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum2_reg <= sum_next;
            str2_reg <= sum_next > {2'b0, rr_reg};
            raw2_reg <= raw1_reg;
        end
    end

    // Square root over SB+2 bits; payload is {stretched, raw fields}
    logic sq_v;
    logic [LB:0] len_w;
    logic [PAY-1:0] sq_pay;
    dsf_sqrt #(.IN_BITS(SB+2), .PAY_BITS(PAY)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2_reg),
        .radicand(sum2_reg), .pay_in({str2_reg, raw2_reg}),
        .out_valid(sq_v), .root(len_w), .pay_out(sq_pay)
    );

    // Stage: excess and operands
    logic [LB:0] rest_s;
    assign rest_s = {2'b0, sq_pay[7*CB-2:6*CB]};
    logic v3_reg;
    logic [LB:0] exc3_reg, len3_reg;
    logic [PAY-1:0] pay3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= sq_v;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len3_reg <= len_w;
            exc3_reg <= (len_w > rest_s) ? len_w - rest_s : '0;
            pay3_reg <= sq_pay;
        end
    end

    // Stage: |d|*E products
    localparam int NB = 2*CB + 1;
    logic signed [CB-1:0] d3 [3];
    logic [CB-1:0] dm3 [3];
    logic [NB-1:0] pr_next [3];
    for (genvar i = 0; i < 3; i++) begin : g_prod
        assign d3[i] = pay3_reg[i*CB +: CB];
        assign dm3[i] = d3[i][CB-1] ? CB'(-d3[i]) : CB'(d3[i]);
        assign pr_next[i] = {{(NB-CB){1'b0}}, dm3[i]} * {{(NB-LB-1){1'b0}}, exc3_reg};
    end
    logic v4_reg;
    logic [NB-1:0] pr4_reg [3];
    logic [LB:0] len4_reg;
    logic [PAY-1:0] pay4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr4_reg  <= pr_next;
            len4_reg <= len3_reg;
            pay4_reg <= pay3_reg;
        end
    end

    // Three dividers; len==0 only when not stretched, result then unused.
    logic dv_v [3];
    logic [NB-1:0] qw [3];
    logic [PAY-1:0] dpay [3];
    for (genvar i = 0; i < 3; i++) begin : g_div
        dsf_div #(.NB(NB), .PAY_BITS(PAY)) u_div (
            .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4_reg),
            .dividend(pr4_reg[i]), .divisor(NB'(len4_reg)), .pay_in(pay4_reg),
            .out_valid(dv_v[i]), .quotient(qw[i]), .pay_out(dpay[i])
        );
    end

    // Stage: gain products (q < 2^CB since |d| <= len)
    logic [CB+dsf_pkg::GAIN_BITS-1:0] sm_next [3], pm_next [3];
    for (genvar i = 0; i < 3; i++) begin : g_gain
        logic signed [CB-1:0] vv;
        logic [CB-1:0] vm;
        assign vv = dpay[0][3*CB + i*CB +: CB];
        assign vm = vv[CB-1] ? CB'(-vv) : CB'(vv);
        assign sm_next[i] = {{dsf_pkg::GAIN_BITS{1'b0}}, qw[i][CB-1:0]}
                          * {{CB{1'b0}}, stiff_reg};
        assign pm_next[i] = {{dsf_pkg::GAIN_BITS{1'b0}}, vm} * {{CB{1'b0}}, damp_reg};
    end
    logic v5_reg;
    logic [CB-1:0] sm5_reg [3], pm5_reg [3];
    logic [PAY-1:0] pay5_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= dv_v[0];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sm5_reg[i] <= sm_next[i][dsf_pkg::GAIN_BITS +: CB];
                pm5_reg[i] <= pm_next[i][dsf_pkg::GAIN_BITS +: CB];
            end
            pay5_reg <= dpay[0];
        end
    end

    // Output stage: signs, subtract, saturate
    logic signed [FB-1:0] f_next [3];
    logic str5;
    assign str5 = pay5_reg[PAY-1];
    for (genvar i = 0; i < 3; i++) begin : g_out
        logic signed [63:0] s, p;
        always_comb
        begin
            s = 64'(signed'({1'b0, sm5_reg[i]}));
            p = 64'(signed'({1'b0, pm5_reg[i]}));
            if (pay5_reg[i*CB + CB-1])
                s = -s;
            if (pay5_reg[3*CB + i*CB + CB-1])
                p = -p;
            f_next[i] = str5 ? dsf_pkg::sat_force(s - p) : '0;
        end
    end

    logic [87:0] out_reg;
    logic ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= v5_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= {6'b0, str5, f_next[2], f_next[1], f_next[0]};
    end
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;

    // The force is zero whenever the spring is not stretched.
    a_zero_slack: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[81] |-> m_axis_tdata[80:0] == '0)
        else $error("force on slack spring");
    // A stall holds the output item.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    // Dividers advance in lockstep.
    a_lock: assert property (@(posedge clk) disable iff (!rst_n)
        dv_v[0] == dv_v[1] && dv_v[1] == dv_v[2])
        else $error("divider lanes out of step");
endmodule
`default_nettype wire

// File: tb/sv/damped_spring_force_checker.sv
// Checker: watches the spring and force channels, predicts each force item and compares.
`default_nettype none
module damped_spring_force_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire [dsf_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire [dsf_pkg::GAIN_BITS-1:0]    cfg_data,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire [167:0] s_axis_tdata,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire [87:0]  m_axis_tdata,
    output int          fail_count,
    output int          pending_count
);
    typedef struct packed {
        logic [dsf_pkg::FORCE_BITS-1:0] fx;
        logic [dsf_pkg::FORCE_BITS-1:0] fy;
        logic [dsf_pkg::FORCE_BITS-1:0] fz;
        logic                           stretched;
    } force_t;

    logic [dsf_pkg::GAIN_BITS-1:0] stiffness_q;
    logic [dsf_pkg::GAIN_BITS-1:0] damping_q;
    force_t                        force_queue[$];

    function automatic longint unsigned isqrt(input longint unsigned s);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (trial * trial <= s)
                r = trial;
        end
        return r;
    endfunction

    function automatic force_t spring_force(input logic [167:0] item,
                                            input logic [dsf_pkg::GAIN_BITS-1:0] k,
                                            input logic [dsf_pkg::GAIN_BITS-1:0] c);
        longint d[3];
        longint v[3];
        longint unsigned rest;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned excess;
        longint unsigned dm;
        longint unsigned vm;
        longint unsigned q;
        longint unsigned sm;
        longint unsigned pm;
        longint f;
        logic [dsf_pkg::FORCE_BITS-1:0] comp[3];
        force_t res;
        sum  = 0;
        rest = longint'(item[166:144]);
        for (int i = 0; i < 3; i++)
        begin
            d[i] = longint'($signed(item[24*i +: 24]));
            v[i] = longint'($signed(item[72 + 24*i +: 24]));
            dm = (d[i] < 0) ? -d[i] : d[i];
            sum += dm * dm;
        end
        res = '0;
        if (sum <= rest * rest)
            return res;             // at or inside rest length: pull-only, no damping
        len    = isqrt(sum);
        excess = (len > rest) ? len - rest : 0;
        for (int i = 0; i < 3; i++)
        begin
            dm = (d[i] < 0) ? -d[i] : d[i];
            vm = (v[i] < 0) ? -v[i] : v[i];
            q  = (len != 0) ? (dm * excess) / len : 0;
            sm = (q * k) >> 16;
            pm = (vm * c) >> 16;
            f  = ((d[i] < 0) ? -longint'(sm) : longint'(sm))
               - ((v[i] < 0) ? -longint'(pm) : longint'(pm));
            if (f > (64'sd1 <<< 26) - 1)
                f = (64'sd1 <<< 26) - 1;
            else if (f < -(64'sd1 <<< 26))
                f = -(64'sd1 <<< 26);
            comp[i] = f[dsf_pkg::FORCE_BITS-1:0];
        end
        res.fx = comp[0];
        res.fy = comp[1];
        res.fz = comp[2];
        res.stretched = 1'b1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_q <= '0;
            damping_q   <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == dsf_pkg::REG_STIFFNESS)
                stiffness_q <= cfg_data;
            else if (cfg_index == dsf_pkg::REG_DAMPING)
                damping_q <= cfg_data;
        end
    end

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    always @(posedge clk)
    begin
        force_t got;
        force_t want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            force_queue.push_back(spring_force(s_axis_tdata, stiffness_q, damping_q));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.fx = m_axis_tdata[26:0];
            got.fy = m_axis_tdata[53:27];
            got.fz = m_axis_tdata[80:54];
            got.stretched = m_axis_tdata[81];
            if (force_queue.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("force item with none expected: %h", m_axis_tdata);
            end
            else
            begin
                want = force_queue.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"force mismatch: exp x=%h y=%h z=%h s=%b",
                                  " got x=%h y=%h z=%h s=%b"},
                                 want.fx, want.fy, want.fz, want.stretched,
                                 got.fx, got.fy, got.fz, got.stretched);
                end
            end
        end
        pending_count = force_queue.size();
    end
endmodule
`default_nettype wire

// File: tb/sv/damped_spring_force_top_test.sv
// Testbench top: drives spring items and gain writes, gives the verdict.
`default_nettype none
module damped_spring_force_top_test;
    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 100;      // pipeline is 80 deep
    localparam int PHASE_ITEMS  = 335;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [dsf_pkg::CFG_IDX_BITS-1:0] cfg_index = dsf_pkg::REG_STIFFNESS;
    logic [dsf_pkg::GAIN_BITS-1:0]    cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // pos x,y,z, vel x,y,z (24 each), rest_length (23), pad bit
    logic [167:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // force_x, force_y, force_z (27 each), stretched, pad
    logic [87:0]  m_axis_tdata;

    int fail_count;
    int pending_count;
    int cycle_count = 0;

    // idle rates in percent; hold_request starts one long receiver stall
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;

    always #2 clk = ~clk;

    damped_spring_force_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    damped_spring_force_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // Receiver: random stalls, plus one long hold-off counted here so the
    // pipeline fills and pushes back on the sender.
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Run-away guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("damped_spring_force_top_test failed");
            $finish;
        end
    end

    // Fields are taken as ints and cut to their widths here.
    function automatic logic [167:0] spring_item(input int dx, input int dy, input int dz,
                                                 input int vx, input int vy, input int vz,
                                                 input int rest);
        return {1'b0, 23'(rest), 24'(vz), 24'(vy), 24'(vx), 24'(dz), 24'(dy), 24'(dx)};
    endfunction

    // Offer one item; valid stays high straight into the next item unless
    // the sender decides to idle.
    task automatic send_spring(input logic [167:0] item);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain_pipeline;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gains(input logic [15:0] k, input logic [15:0] c);
        cfg_we    <= 1'b1;
        cfg_index <= dsf_pkg::REG_STIFFNESS;
        cfg_data  <= k;
        @(posedge clk);
        cfg_index <= dsf_pkg::REG_DAMPING;
        cfg_data  <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random coordinate at a random scale: small values dominate so that
    // rest lengths land on both sides of the spring length.
    function automatic logic [23:0] rand_coord();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return 24'($signed(13'($urandom())));
        else if (sel < 7)
            return 24'($signed(19'($urandom())));
        else
            return 24'($urandom());
    endfunction

    function automatic int unsigned coord_mag(input logic [23:0] c);
        return c[23] ? 32'(-$signed(c)) : 32'(c);
    endfunction

    function automatic logic [167:0] random_spring();
        logic [23:0] dx;
        logic [23:0] dy;
        logic [23:0] dz;
        int unsigned reach;
        logic [22:0] rest;
        dx = rand_coord();
        dy = rand_coord();
        dz = rand_coord();
        // |d| lies between the largest component and the sum of all three
        reach = coord_mag(dx) + coord_mag(dy) + coord_mag(dz);
        if ($urandom_range(4) == 0)
            rest = 23'($urandom());
        else
            rest = 23'($urandom_range(reach > 23'h7fffff ? 23'h7fffff : reach));
        return spring_item(dx, dy, dz, rand_coord(), rand_coord(), rand_coord(), rest);
    endfunction

    task automatic run_directed;
        logic [23:0] mx;
        logic [23:0] mn;
        mx = 24'h7fffff;
        mn = 24'h800000;
        send_spring(spring_item(0, 0, 0, mx, mn, mx, 0));          // zero length, zero rest
        send_spring(spring_item(1, 0, 0, 0, 0, 0, 0));              // tiniest stretch
        send_spring(spring_item(-1, 0, 0, 5, -5, 0, 0));
        send_spring(spring_item(768, 1024, 0, 300, 0, 0, 1280));    // length equals rest
        send_spring(spring_item(768, 1024, 0, 300, 0, 0, 1279));    // one past rest
        send_spring(spring_item(-768, 0, -1024, 0, -300, 0, 1279));
        send_spring(spring_item(mn, mn, mn, mx, mx, mx, 0));
        send_spring(spring_item(mx, mx, mx, mn, mn, mn, 0));
        send_spring(spring_item(mx, mx, mx, mn, mn, mn, 23'h7fffff));
        send_spring(spring_item(mn, 0, 0, mx, 0, 0, 23'h7fffff));   // 2^23 just past rest
        send_spring(spring_item(mx, 0, 0, mx, 0, 0, 23'h7fffff));   // length equals rest
        send_spring(spring_item(0, mn, 0, 0, mn, 0, 0));
        send_spring(spring_item(0, 0, mx, 0, 0, mn, 100));
        send_spring(spring_item(0, 0, 0, mn, mn, mn, 23'h7fffff));  // not stretched, big v
        send_spring(spring_item(256, -256, 256, -1, 1, -1, 256));
        send_spring(spring_item(24'h555555, 24'haaaaaa, 24'h0f0f0f,
                                24'haaaaaa, 24'h555555, 24'hf0f0f0, 23'h2aaaaa));
    endtask

    initial
    begin
        logic [15:0] gains_k[6];
        logic [15:0] gains_c[6];
        gains_k = '{16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'h0000};
        gains_c = '{16'hffff, 16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'h0000};
        gains_k[4] = 16'($urandom());
        gains_c[4] = 16'($urandom());
        gains_k[5] = 16'($urandom());
        gains_c[5] = 16'($urandom());

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 6; phase++)
        begin
            write_gains(gains_k[phase], gains_c[phase]);
            // sender 31% / receiver 53% idle for two phases, swapped for two, then none
            if (phase < 2)
            begin
                sender_idle_pct   = 31;
                receiver_idle_pct = 53;
            end
            else if (phase < 4)
            begin
                sender_idle_pct   = 53;
                receiver_idle_pct = 31;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            if (phase == 0)
                run_directed();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 4 && n == 20)
                    hold_request = 1'b1;
                send_spring(random_spring());
            end
            drain_pipeline();
        end

        if (fail_count == 0)
            $display("damped_spring_force_top_test passed");
        else
            $display("damped_spring_force_top_test failed");
        $finish;
    end
endmodule
`default_nettype wire
